[hw/rtl/servo_board_reply_deframer_defines.svh]
// Assertion helpers for the servo board reply deframer.
`ifndef SERVO_BOARD_REPLY_DEFRAMER_DEFINES_SVH
`define SERVO_BOARD_REPLY_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbrd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbrd: next-cycle check failed");

`endif

[hw/rtl/sbrd_pkg.sv]
`default_nettype none

package sbrd_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int SERVO_SLOTS = 8;
    localparam int MAX_RESULTS = 9;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 16;
    localparam int TOTAL_W = 9;

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int FILL_W = ADDR_W + 1;
    localparam int SLOT_W = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    // frame layout: header, header, length, command, payload...
    localparam logic [FILL_W-1:0]  FILL_CMD     = FILL_W'(3);
    localparam logic [ADDR_W-1:0]  PAY_BASE     = ADDR_W'(4);
    localparam logic [TOTAL_W-1:0] LEN_OVERHEAD = TOTAL_W'(2);
    localparam logic [BYTE_W-1:0]  PLEN_MIN_BAT = BYTE_W'(2);
    localparam logic [VALUE_W-1:0] POS_RESET    = VALUE_W'(500);

    localparam logic [KIND_W-1:0] KIND_PLAIN    = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_BATTERY  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_POSITION = KIND_W'(2);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CMD_POSITION   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CMD_BATTERY    = CFG_IDX_W'(3);

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = BYTE_W'(85);
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = BYTE_W'(85);
    localparam logic [BYTE_W-1:0] RST_CMD_POSITION  = BYTE_W'(21);
    localparam logic [BYTE_W-1:0] RST_CMD_BATTERY   = BYTE_W'(15);

    typedef enum logic [2:0] {
        RD_PAY_FIRST,
        RD_PAY_SECOND,
        RD_ENTRY_ID,
        RD_ENTRY_LO,
        RD_ENTRY_HI
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_PLAIN,
        OUT_BATTERY,
        OUT_PENDING
    } t_out_sel;

    typedef struct packed {
        logic     len_load;
        logic     body_write;
        logic     walk_init;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     id_take;
        logic     lo_take;
        logic     entry_step;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_first_hit;
        logic hdr_second_hit;
        logic body_done;
        logic body_full;
        logic is_position;
        logic is_battery;
        logic plen_ge1;
        logic plen_ge2;
        logic walk_more;
        logic id_in_range;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/sbrd_rx_if.sv]
`default_nettype none

interface sbrd_rx_if import sbrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbrd_res_if.sv]
`default_nettype none

interface sbrd_res_if import sbrd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  command;
    logic [BYTE_W-1:0]  unit_id;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output kind, output command, output unit_id,
                    output value, output last, input ready);
    modport sink (input valid, input kind, input command, input unit_id,
                  input value, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbrd_ram.sv]
`default_nettype none

module sbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/sbrd_ctrl.sv]
`default_nettype none

module sbrd_ctrl import sbrd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_HUNT_FIRST,
        S_HUNT_SECOND,
        S_LENGTH,
        S_BODY,
        S_DECODE,
        S_COUNT,
        S_WALK,
        S_ENTRY_ID,
        S_ENTRY_LO,
        S_ENTRY_HI,
        S_BAT_LO,
        S_BAT_HI
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    in_ready;
    logic    accept;

    assign in_ready = (r_state == S_HUNT_FIRST) || (r_state == S_HUNT_SECOND) ||
                      (r_state == S_LENGTH) || (r_state == S_BODY);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_HUNT_FIRST: begin
                if (accept && i_status.hdr_first_hit) begin
                    n_state = S_HUNT_SECOND;
                end
            end
            S_HUNT_SECOND: begin
                // a mismatch is not retried as a first header
                if (accept) begin
                    n_state = i_status.hdr_second_hit ? S_LENGTH : S_HUNT_FIRST;
                end
            end
            S_LENGTH: begin
                if (accept) begin
                    cmd.len_load = 1'b1;
                    n_state      = S_BODY;
                end
            end
            S_BODY: begin
                if (accept) begin
                    cmd.body_write = 1'b1;
                    if (i_status.body_done) begin
                        n_state = S_DECODE;
                    end else if (i_status.body_full) begin
                        n_state = S_HUNT_FIRST;
                    end
                end
            end
            S_DECODE: begin
                if (i_status.is_position && i_status.plen_ge1) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PAY_FIRST;
                    n_state    = S_COUNT;
                end else if (!i_status.is_position && i_status.is_battery &&
                             i_status.plen_ge2) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PAY_FIRST;
                    n_state    = S_BAT_LO;
                end else if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PLAIN;
                    cmd.out_last = 1'b1;
                    n_state      = S_HUNT_FIRST;
                end
            end
            S_COUNT: begin
                cmd.walk_init = 1'b1;
                n_state       = S_WALK;
            end
            S_WALK: begin
                if (i_status.walk_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ENTRY_ID;
                    n_state    = S_ENTRY_ID;
                end else if (i_status.out_free) begin
                    // flush the held update, or report a plain frame if none
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = i_status.pend_valid ? OUT_PENDING : OUT_PLAIN;
                    cmd.out_last = 1'b1;
                    n_state      = S_HUNT_FIRST;
                end
            end
            S_ENTRY_ID: begin
                cmd.id_take = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_ENTRY_LO;
                n_state     = S_ENTRY_LO;
            end
            S_ENTRY_LO: begin
                cmd.lo_take = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_ENTRY_HI;
                n_state     = S_ENTRY_HI;
            end
            S_ENTRY_HI: begin
                // a new update pushes the held one out, which is then not last
                if (i_status.id_in_range && i_status.pend_valid) begin
                    if (i_status.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_sel    = OUT_PENDING;
                        cmd.entry_step = 1'b1;
                        n_state        = S_WALK;
                    end
                end else begin
                    cmd.entry_step = 1'b1;
                    n_state        = S_WALK;
                end
            end
            S_BAT_LO: begin
                cmd.lo_take = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_PAY_SECOND;
                n_state     = S_BAT_HI;
            end
            S_BAT_HI: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_BATTERY;
                    cmd.out_last = 1'b1;
                    n_state      = S_HUNT_FIRST;
                end
            end
            default: begin
                n_state = S_HUNT_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT_FIRST;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

[hw/rtl/sbrd_datapath.sv]
`default_nettype none

module sbrd_datapath import sbrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [KIND_W-1:0]     o_kind,
    output logic [BYTE_W-1:0]     o_command,
    output logic [BYTE_W-1:0]     o_unit_id,
    output logic [VALUE_W-1:0]    o_value,
    output logic                  o_last
);

    // configuration
    logic [BYTE_W-1:0] r_hdr_first;
    logic [BYTE_W-1:0] r_hdr_second;
    logic [BYTE_W-1:0] r_cmd_position;
    logic [BYTE_W-1:0] r_cmd_battery;

    // frame capture
    logic [BYTE_W-1:0]  r_len;
    logic [TOTAL_W-1:0] r_total;
    logic [FILL_W-1:0]  r_fill;
    logic [BYTE_W-1:0]  r_cmd;
    logic [FILL_W-1:0]  fill_next;
    logic [BYTE_W-1:0]  plen;

    // reply walk
    logic [BYTE_W-1:0] r_count;
    logic [BYTE_W-1:0] r_idx;
    logic [BYTE_W-1:0] r_walked;
    logic [NRES_W-1:0] r_nres;
    logic              r_pend_valid;
    logic [BYTE_W-1:0] r_pend_id;
    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_lo;
    logic              id_in_range;

    // frame store read side
    logic [BYTE_W-1:0] rd_off;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // servo position table; an entry not yet valid reads as the reset position
    logic [VALUE_W-1:0]     r_pos [SERVO_SLOTS];
    logic [SERVO_SLOTS-1:0] r_slot_valid;
    logic [SLOT_W-1:0]      w_slot;
    logic [SLOT_W-1:0]      pend_slot;
    logic [VALUE_W-1:0]     pend_pos;
    logic [VALUE_W-1:0]     word;

    // result register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [BYTE_W-1:0]  r_command;
    logic [BYTE_W-1:0]  r_unit_id;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;
    logic               out_free;

    assign fill_next   = r_fill + FILL_W'(1);
    assign plen        = (r_len >= PLEN_MIN_BAT) ? (r_len - PLEN_MIN_BAT) : '0;
    assign id_in_range = (r_id != '0) && (r_id <= BYTE_W'(SERVO_SLOTS));
    assign w_slot      = SLOT_W'(r_id - BYTE_W'(1));
    assign pend_slot   = SLOT_W'(r_pend_id - BYTE_W'(1));
    assign pend_pos    = r_slot_valid[pend_slot] ? r_pos[pend_slot] : POS_RESET;
    assign word        = {rd_data, r_lo};
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PAY_FIRST:  rd_off = BYTE_W'(0);
            RD_PAY_SECOND: rd_off = BYTE_W'(1);
            RD_ENTRY_ID:   rd_off = r_idx;
            RD_ENTRY_LO:   rd_off = r_idx + BYTE_W'(1);
            RD_ENTRY_HI:   rd_off = r_idx + BYTE_W'(2);
            default:       rd_off = '0;
        endcase
    end

    assign rd_addr = PAY_BASE + ADDR_W'(rd_off);

    sbrd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.body_write),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first    <= RST_HEADER_FIRST;
            r_hdr_second   <= RST_HEADER_SECOND;
            r_cmd_position <= RST_CMD_POSITION;
            r_cmd_battery  <= RST_CMD_BATTERY;
            r_fill         <= '0;
            r_total        <= '0;
            r_nres         <= '0;
            r_pend_valid   <= 1'b0;
            r_slot_valid   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HEADER_FIRST:  r_hdr_first    <= i_cfg_data;
                    REG_HEADER_SECOND: r_hdr_second   <= i_cfg_data;
                    REG_CMD_POSITION:  r_cmd_position <= i_cfg_data;
                    REG_CMD_BATTERY:   r_cmd_battery  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.len_load) begin
                r_total <= TOTAL_W'(i_rx_byte) + LEN_OVERHEAD;
                r_fill  <= FILL_CMD;
            end else if (i_cmd.body_write) begin
                r_fill <= fill_next;
            end
            if (i_cmd.walk_init) begin
                r_nres       <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.entry_step && id_in_range) begin
                r_nres               <= r_nres + NRES_W'(1);
                r_pend_valid         <= 1'b1;
                r_slot_valid[w_slot] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len <= i_rx_byte;
        end
        if (i_cmd.body_write && (r_fill == FILL_CMD)) begin
            r_cmd <= i_rx_byte;
        end
        if (i_cmd.walk_init) begin
            r_count  <= rd_data;
            r_idx    <= BYTE_W'(1);
            r_walked <= '0;
        end else if (i_cmd.entry_step) begin
            r_idx    <= r_idx + BYTE_W'(3);
            r_walked <= r_walked + BYTE_W'(1);
            if (id_in_range) begin
                r_pend_id     <= r_id;
                r_pos[w_slot] <= word;
            end
        end
        if (i_cmd.id_take) begin
            r_id <= rd_data;
        end
        if (i_cmd.lo_take) begin
            r_lo <= rd_data;
        end
        if (i_cmd.out_load) begin
            r_command <= r_cmd;
            r_last    <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OUT_BATTERY: begin
                    r_kind    <= KIND_BATTERY;
                    r_unit_id <= '0;
                    r_value   <= word;
                end
                OUT_PENDING: begin
                    r_kind    <= KIND_POSITION;
                    r_unit_id <= r_pend_id;
                    r_value   <= pend_pos;
                end
                default: begin
                    r_kind    <= KIND_PLAIN;
                    r_unit_id <= '0;
                    r_value   <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_status                = '0;
        o_status.hdr_first_hit  = (i_rx_byte == r_hdr_first);
        o_status.hdr_second_hit = (i_rx_byte == r_hdr_second);
        o_status.body_done      = (TOTAL_W'(fill_next) >= r_total);
        o_status.body_full      = (fill_next == FILL_W'(FRAME_BYTES));
        o_status.is_position    = (r_cmd == r_cmd_position);
        o_status.is_battery     = (r_cmd == r_cmd_battery);
        o_status.plen_ge1       = (plen != '0);
        o_status.plen_ge2       = (plen >= PLEN_MIN_BAT);
        o_status.walk_more      = (r_walked < r_count) &&
                                  ((TOTAL_W'(r_idx) + TOTAL_W'(2)) < TOTAL_W'(plen)) &&
                                  (r_nres < NRES_W'(MAX_RESULTS));
        o_status.id_in_range    = id_in_range;
        o_status.pend_valid     = r_pend_valid;
        o_status.out_free       = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_command   = r_command;
    assign o_unit_id   = r_unit_id;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[hw/rtl/servo_board_reply_deframer.sv]
// Servo board reply deframer: takes link bytes on i_rx, finds frames of two header bytes,
// a length byte, a command and length-2 payload bytes, and emits results on o_res (the
// last result of a frame has last set). While a frame is being received one byte is
// taken per cycle. After its final byte the input stalls while the frame is decoded out
// of the 32-byte frame store, which has one read port and returns one byte per cycle:
// a plain frame needs no read, a battery reply reads two payload bytes and a position
// reply the count, then id, low and high byte per entry walked (at most nine entries);
// results wait for a free result register. Position updates go to an eight-slot table;
// unwritten slots read as 500. The user must write the four header and command registers
// through i_cfg_we / i_cfg_index / i_cfg_data while idle; the block does not enforce it.
`default_nettype none

`include "servo_board_reply_deframer_defines.svh"

module servo_board_reply_deframer import sbrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sbrd_rx_if.sink               i_rx,
    sbrd_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    sbrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sbrd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_kind      (o_res.kind),
        .o_command   (o_res.command),
        .o_unit_id   (o_res.unit_id),
        .o_value     (o_res.value),
        .o_last      (o_res.last)
    );

    assign i_rx.ready = in_ready;

    // no result is produced while bytes are being taken in
    `SBRD_ASSERT_SAME(a_no_load_on_rx, i_clk, i_rst_n, i_rx.valid && i_rx.ready, !dp_cmd.out_load)
    // a new result never overwrites one that is still waiting
    `SBRD_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, dp_cmd.out_load, !o_res.valid || o_res.ready)
    // the final result of a frame returns the block to hunting
    `SBRD_ASSERT_NEXT(a_last_rearms, i_clk, i_rst_n, dp_cmd.out_load && dp_cmd.out_last, i_rx.ready)
    // position updates only name servos in range
    `SBRD_ASSERT_SAME(a_pos_id_range, i_clk, i_rst_n, o_res.valid && o_res.kind == KIND_POSITION, o_res.unit_id != 8'd0 && o_res.unit_id <= 8'(SERVO_SLOTS))

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb import sbrd_pkg::*; ();

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  command;
        logic [BYTE_W-1:0]  unit_id;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_reply;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        GET_LENGTH,
        GET_BODY
    } t_seek;

    localparam int DRAIN_CYCLES = 64;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sbrd_rx_if  rx ();
    sbrd_res_if res ();

    servo_board_reply_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx),
        .o_res       (res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // deframer copy: registers and state
    t_byte              hdr_first;
    t_byte              hdr_second;
    t_byte              cmd_pos;
    t_byte              cmd_bat;
    t_seek              parse_state;
    t_byte              frame_buf [FRAME_BYTES];
    int                 fill;
    int                 frame_total;
    logic [VALUE_W-1:0] pos_table [SERVO_SLOTS];
    logic               pos_seen [SERVO_SLOTS];

    t_reply pending[$];
    int     bytes_sent;
    int     results_due;
    int     mismatches;
    bit     calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_model();
        hdr_first   = RST_HEADER_FIRST;
        hdr_second  = RST_HEADER_SECOND;
        cmd_pos     = RST_CMD_POSITION;
        cmd_bat     = RST_CMD_BATTERY;
        parse_state = SEEK_FIRST;
        fill        = 0;
        frame_total = 0;
        foreach (frame_buf[k]) frame_buf[k] = '0;
        foreach (pos_table[k]) begin
            pos_table[k] = POS_RESET;
            pos_seen[k]  = 1'b0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte data);
        case (idx)
            REG_HEADER_FIRST:  hdr_first  = data;
            REG_HEADER_SECOND: hdr_second = data;
            REG_CMD_POSITION:  cmd_pos    = data;
            REG_CMD_BATTERY:   cmd_bat    = data;
            default: ;
        endcase
    endfunction

    function automatic t_reply make_reply(input logic [KIND_W-1:0] kind, input t_byte cmd,
                                          input t_byte id, input logic [VALUE_W-1:0] val);
        t_reply r;
        r.kind    = kind;
        r.command = cmd;
        r.unit_id = id;
        r.value   = val;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic void decode_reply();
        t_reply             frame_q[$];
        t_byte              cmd;
        int                 plen;
        int                 cnt;
        int                 idx;
        int                 id;
        logic [VALUE_W-1:0] pos;
        cmd  = frame_buf[3];
        plen = (int'(frame_buf[2]) >= 2) ? int'(frame_buf[2]) - 2 : 0;
        if (cmd == cmd_pos) begin
            if (plen >= 1) begin
                cnt = frame_buf[4];
                idx = 1;
                for (int i = 0; i < cnt && idx + 2 < plen && frame_q.size() < MAX_RESULTS; i++) begin
                    id  = frame_buf[4 + idx];
                    pos = {frame_buf[4 + idx + 2], frame_buf[4 + idx + 1]};
                    idx += 3;
                    // skip ids outside the table
                    if (id >= 1 && id <= SERVO_SLOTS) begin
                        pos_table[id - 1] = pos;
                        pos_seen[id - 1]  = 1'b1;
                        frame_q.push_back(make_reply(KIND_POSITION, cmd, t_byte'(id), pos));
                    end
                end
            end
        end else if (cmd == cmd_bat && plen >= 2) begin
            frame_q.push_back(make_reply(KIND_BATTERY, cmd, '0, {frame_buf[5], frame_buf[4]}));
        end
        if (frame_q.size() == 0) frame_q.push_back(make_reply(KIND_PLAIN, cmd, '0, '0));
        frame_q[frame_q.size() - 1].last = 1'b1;
        foreach (frame_q[k]) pending.push_back(frame_q[k]);
        results_due += frame_q.size();
    endfunction

    function automatic void parse_rx_byte(input t_byte b);
        case (parse_state)
            SEEK_FIRST: begin
                if (b == hdr_first) begin
                    frame_buf[0] = b;
                    parse_state  = SEEK_SECOND;
                end
            end
            SEEK_SECOND: begin
                if (b == hdr_second) begin
                    frame_buf[1] = b;
                    parse_state  = GET_LENGTH;
                end else begin
                    parse_state = SEEK_FIRST;
                end
            end
            GET_LENGTH: begin
                frame_buf[2] = b;
                frame_total  = int'(b) + 2;
                fill         = 3;
                parse_state  = GET_BODY;
            end
            default: begin
                if (fill < FRAME_BYTES) begin
                    frame_buf[fill] = b;
                    fill++;
                    if (fill >= frame_total) begin
                        parse_state = SEEK_FIRST;
                        decode_reply();
                        fill = 0;
                    end else if (fill >= FRAME_BYTES) begin
                        // drop the frame, it cannot fit
                        fill        = 0;
                        parse_state = SEEK_FIRST;
                    end
                end else begin
                    fill        = 0;
                    parse_state = SEEK_FIRST;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_reply want;
        if (pending.size() == 0) begin
            report_mismatch("result with nothing pending, command", res.command, 0);
            return;
        end
        want = pending.pop_front();
        if (res.kind !== want.kind) report_mismatch("kind", res.kind, want.kind);
        if (res.command !== want.command) report_mismatch("command", res.command, want.command);
        if (res.unit_id !== want.unit_id) report_mismatch("unit_id", res.unit_id, want.unit_id);
        if (res.value !== want.value) report_mismatch("value", res.value, want.value);
        if (res.last !== want.last) report_mismatch("last", res.last, want.last);
    endtask

    // one process for both sides keeps prediction ahead of checking in a step
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (rx.valid === 1'b1 && rx.ready === 1'b1) parse_rx_byte(rx.rx_byte);
            if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
        end
    end

    initial begin
        int hold;
        hold      = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res.ready <= 1'b0;
                hold--;
            end else begin
                res.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20) hold = pick_gap() + 1;
            end
        end
    end

    task automatic send_byte(input t_byte b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge i_clk); while (rx.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte len, input t_byte cmd, input t_byte body[$]);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(len);
        send_byte(cmd);
        foreach (body[k]) send_byte(body[k]);
    endtask

    // drop valid, drain every pending result, then let the decoder go quiet
    task automatic settle();
        @(negedge i_clk);
        rx.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        apply_reg(idx, data);
    endtask

    task automatic load_config(input t_byte hf, input t_byte hs, input t_byte cp, input t_byte cb);
        settle();
        write_reg(REG_HEADER_FIRST, hf);
        write_reg(REG_HEADER_SECOND, hs);
        write_reg(REG_CMD_POSITION, cp);
        write_reg(REG_CMD_BATTERY, cb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_plain_frames();
        t_byte body[$];
        body = {};
        send_frame(8'd2, 8'h00, body);
        body = {8'h00, 8'hFF};
        send_frame(8'd4, 8'hFF, body);
    endtask

    task automatic test_header_hunt();
        t_byte body[$];
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hdr_first);
        send_byte(8'h13);
        body = {8'h77};
        send_frame(8'd3, 8'h42, body);
        // a mismatching second byte must not restart as a first header
        load_config(8'hA5, 8'h5A, RST_CMD_POSITION, RST_CMD_BATTERY);
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h02);
        send_byte(8'h07);
        body = {};
        send_frame(8'd2, 8'h33, body);
        load_config(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_CMD_POSITION, RST_CMD_BATTERY);
    endtask

    task automatic test_short_length();
        t_byte body[$];
        body = {};
        send_frame(8'd0, cmd_bat, body);
        send_frame(8'd1, cmd_pos, body);
    endtask

    task automatic test_battery();
        t_byte body[$];
        body = {8'h34, 8'h12};
        send_frame(8'd4, cmd_bat, body);
        body = {8'h99};
        send_frame(8'd3, cmd_bat, body);
        body = {8'hFF, 8'hFF, 8'h00};
        send_frame(8'd5, cmd_bat, body);
    endtask

    task automatic test_position_walk();
        t_byte              body[$];
        logic [VALUE_W-1:0] pos;
        // skipped ids, a repeated id and a count larger than the entries
        body = {8'd6, 8'd1, 8'h00, 8'h00, 8'd9, 8'h11, 8'h22, 8'd8, 8'hFF, 8'hFF,
                8'd1, 8'h34, 8'h12, 8'hFF, 8'h01, 8'h02};
        send_frame(t_byte'(body.size() + 2), cmd_pos, body);
        body = {8'd1, 8'd2, 8'hE8, 8'h03, 8'd3, 8'h10, 8'h00};
        send_frame(t_byte'(body.size() + 2), cmd_pos, body);
        body = {8'd2, 8'd4, 8'h56, 8'h78, 8'd5, 8'h9A};
        send_frame(t_byte'(body.size() + 2), cmd_pos, body);
        // nine updates fill the store to the last byte
        body = {8'd9};
        for (int k = 0; k < 9; k++) begin
            pos = VALUE_W'($urandom);
            body.push_back(t_byte'((k % SERVO_SLOTS) + 1));
            body.push_back(pos[7:0]);
            body.push_back(pos[15:8]);
        end
        send_frame(t_byte'(body.size() + 2), cmd_pos, body);
        body = {8'd0, 8'd1, 8'h00, 8'h01};
        send_frame(t_byte'(body.size() + 2), cmd_pos, body);
    endtask

    task automatic test_buffer_full();
        t_byte body[$];
        body = {};
        repeat (FRAME_BYTES - 4) body.push_back(t_byte'($urandom));
        send_frame(8'd31, 8'h42, body);
        body = {8'h01, 8'h02};
        send_frame(8'd4, cmd_bat, body);
    endtask

    task automatic test_register_clash();
        t_byte body[$];
        load_config(RST_HEADER_FIRST, RST_HEADER_SECOND, 8'h42, 8'h42);
        body = {8'd1, 8'd3, 8'h10, 8'h27};
        send_frame(8'd6, 8'h42, body);
        body = {8'h34, 8'h12};
        send_frame(8'd4, 8'h42, body);
    endtask

    task automatic test_config_extremes();
        t_byte body[$];
        load_config(8'h00, 8'hFF, 8'hFF, 8'h00);
        body = {8'hFF, 8'hFF};
        send_frame(8'd4, 8'h00, body);
        body = {8'd1, 8'd7, 8'hFF, 8'hFF};
        send_frame(8'd6, 8'hFF, body);
        load_config(8'hFF, 8'h00, 8'h00, 8'hFF);
        body = {8'h00, 8'h80};
        send_frame(8'd4, 8'hFF, body);
        body = {8'd1, 8'd8, 8'h00, 8'h80};
        send_frame(8'd6, 8'h00, body);
        body = {};
        send_frame(8'd2, 8'h80, body);
    endtask

    task automatic send_random_frame();
        t_byte              body[$];
        int                 pick;
        int                 n_ent;
        logic [VALUE_W-1:0] pos;
        body = {};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            n_ent = $urandom_range(0, 9);
            body.push_back(($urandom_range(0, 3) == 0) ? t_byte'($urandom) : t_byte'(n_ent));
            repeat (n_ent) begin
                pos = VALUE_W'($urandom);
                body.push_back(($urandom_range(0, 5) == 0) ? t_byte'($urandom)
                                                           : t_byte'($urandom_range(1, SERVO_SLOTS)));
                body.push_back(pos[7:0]);
                body.push_back(pos[15:8]);
            end
            // cut the last entry short now and then
            if ($urandom_range(0, 4) == 0 && body.size() > 1) void'(body.pop_back());
            send_frame(t_byte'(body.size() + 2), cmd_pos, body);
        end else if (pick < 60) begin
            repeat ($urandom_range(0, 4)) body.push_back(t_byte'($urandom));
            send_frame(t_byte'(body.size() + 2), cmd_bat, body);
        end else if (pick < 80) begin
            repeat ($urandom_range(0, 8)) body.push_back(t_byte'($urandom));
            send_frame(t_byte'(body.size() + 2), t_byte'($urandom), body);
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) send_byte(t_byte'($urandom));
        end else if (pick < 95) begin
            repeat (FRAME_BYTES - 4) body.push_back(t_byte'($urandom));
            send_frame(t_byte'($urandom_range(FRAME_BYTES - 1, 255)), t_byte'($urandom), body);
        end else begin
            send_byte(hdr_first);
            send_byte(t_byte'($urandom));
        end
    endtask

    task automatic run_traffic_phase(input t_byte hf, input t_byte hs, input t_byte cp,
                                     input t_byte cb, input bit quiet);
        int results0;
        load_config(hf, hs, cp, cb);
        calm     = quiet;
        results0 = results_due;
        while (results_due - results0 < 1) send_random_frame();
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_CMD_POSITION,
                          RST_CMD_BATTERY, 1'b0);
        run_traffic_phase(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                          t_byte'($urandom), 1'b1);
        run_traffic_phase(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
        run_traffic_phase(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0);
        run_traffic_phase(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                          t_byte'($urandom), 1'b0);
    endtask

    initial begin
        rx.valid    = 1'b0;
        rx.rx_byte  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_HEADER_FIRST;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        bytes_sent  = 0;
        results_due = 0;
        mismatches  = 0;
        calm        = 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_frames();
        test_short_length();
        test_battery();
        test_position_walk();
        test_buffer_full();
        test_header_hunt();
        test_register_clash();
        test_config_extremes();
        test_random_traffic();

        settle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/sbrd_pkg.sv
hw/rtl/sbrd_rx_if.sv
hw/rtl/sbrd_res_if.sv
hw/rtl/sbrd_ram.sv
hw/rtl/sbrd_ctrl.sv
hw/rtl/sbrd_datapath.sv
hw/rtl/servo_board_reply_deframer.sv
bench/tb.sv
